// ----- hdl/multi_pin_time_debouncer_macros.svh -----
// Assertion macros used by the debouncer top level.
`ifndef MULTI_PIN_TIME_DEBOUNCER_MACROS_SVH
`define MULTI_PIN_TIME_DEBOUNCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPTD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mptd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mptd: next-cycle check failed");

`endif

// ----- hdl/mptd_pkg.sv -----
// Package: widths, register codes and shared types of the pin debouncer.
`timescale 1ns / 1ps
`default_nettype none
package mptd_pkg;

  localparam int PIN_W     = 8;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REST   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd2;

  localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd40;
  localparam logic [PIN_W-1:0]   REST_RESET   = 8'h00;
  localparam logic [PIN_W-1:0]   ENABLE_RESET = 8'hFF;

  typedef struct packed {
    logic                restart;
    logic [TIME_W-1:0]   now_ms;
    logic [PIN_W-1:0]    pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] activated_mask;
    logic [PIN_W-1:0] deactivated_mask;
    logic [PIN_W-1:0] debounced_levels;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] debounce_delay;
    logic [PIN_W-1:0]   rest_levels;
    logic [PIN_W-1:0]   pin_enable;
  } cfg_t;

  // Common control for every lane in one step.
  typedef struct packed {
    logic               valid;
    logic               restart;
    logic [TIME_W-1:0]  now_ms;
    logic [DELAY_W-1:0] debounce_delay;
  } step_t;

  typedef struct packed {
    logic activated;
    logic deactivated;
    logic level;
  } lane_res_t;

endpackage
`default_nettype wire

// ----- hdl/mptd_if.sv -----
// Interfaces: sample channel and event channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface mptd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             restart;
  logic [mptd_pkg::TIME_W-1:0]      now_ms;
  logic [mptd_pkg::PIN_W-1:0]       pin_levels;

  modport source (output valid, restart, now_ms, pin_levels, input ready);
  modport sink   (input valid, restart, now_ms, pin_levels, output ready);
endinterface

interface mptd_out_if;
  logic                             valid;
  logic                             ready;
  logic [mptd_pkg::PIN_W-1:0]       activated_mask;
  logic [mptd_pkg::PIN_W-1:0]       deactivated_mask;
  logic [mptd_pkg::PIN_W-1:0]       debounced_levels;

  modport source (output valid, activated_mask, deactivated_mask, debounced_levels,
                  input ready);
  modport sink   (input valid, activated_mask, deactivated_mask, debounced_levels,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/mptd_cfg.sv -----
// APB register block: debounce delay, rest levels and pin enable.
`timescale 1ns / 1ps
`default_nettype none
module mptd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mptd_pkg::PADDR_W-1:0]       paddr,
  input  logic [mptd_pkg::APB_DW-1:0]        pwdata,
  output logic [mptd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  output mptd_pkg::cfg_t                     cfg
);

  logic                               wr_en;
  logic [mptd_pkg::REG_IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mptd_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_delay <= mptd_pkg::DELAY_RESET;
      cfg.rest_levels    <= mptd_pkg::REST_RESET;
      cfg.pin_enable     <= mptd_pkg::ENABLE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        mptd_pkg::REG_DELAY:  cfg.debounce_delay <= pwdata[mptd_pkg::DELAY_W-1:0];
        mptd_pkg::REG_REST:   cfg.rest_levels    <= pwdata[mptd_pkg::PIN_W-1:0];
        mptd_pkg::REG_ENABLE: cfg.pin_enable     <= pwdata[mptd_pkg::PIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mptd_pkg::REG_DELAY:  prdata = mptd_pkg::APB_DW'(cfg.debounce_delay);
      mptd_pkg::REG_REST:   prdata = mptd_pkg::APB_DW'(cfg.rest_levels);
      mptd_pkg::REG_ENABLE: prdata = mptd_pkg::APB_DW'(cfg.pin_enable);
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/mptd_lane.sv -----
// One debounce lane: change timer, stable level and reported level.
`timescale 1ns / 1ps
`default_nettype none
module mptd_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  mptd_pkg::step_t      step,
  input  logic                 sample,
  input  logic                 rest,
  input  logic                 enable,
  output mptd_pkg::lane_res_t  res
);

  logic                          prev;
  logic                          stable;
  logic                          reported;
  logic [mptd_pkg::TIME_W-1:0]   last_change;
  logic                          prev_next;
  logic                          stable_next;
  logic                          reported_next;
  logic [mptd_pkg::TIME_W-1:0]   last_change_next;
  logic                          changed;
  logic                          expired;
  logic                          report;
  logic [mptd_pkg::TIME_W-1:0]   elapsed;

  // A fresh change restarts the timer, so it can never expire in that step.
  assign changed = sample ^ prev;
  assign elapsed = step.now_ms - last_change;
  assign expired = !changed && (elapsed > mptd_pkg::TIME_W'(step.debounce_delay));

  always_comb begin
    if (step.restart) begin
      prev_next        = rest;
      stable_next      = rest;
      reported_next    = rest;
      last_change_next = step.now_ms;
      report           = 1'b0;
    end else begin
      prev_next        = sample;
      stable_next      = expired ? sample : stable;
      last_change_next = (changed || expired) ? step.now_ms : last_change;
      report           = enable && (reported != stable_next);
      // Disabled lane keeps its old report so the change fires on re-enable.
      reported_next    = enable ? stable_next : reported;
    end
    res.activated   = report && (stable_next != rest);
    res.deactivated = report && (stable_next == rest);
    res.level       = stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev        <= 1'b0;
      stable      <= 1'b0;
      reported    <= 1'b0;
      last_change <= '0;
    end else if (step.valid) begin
      prev        <= prev_next;
      stable      <= stable_next;
      reported    <= reported_next;
      last_change <= last_change_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/multi_pin_time_debouncer.sv -----
// Top level: time-based debouncer for a bank of pins, APB config, one item per cycle
//   while the event sink keeps up. A sample transaction is held in the input register,
//   then goes through the lane logic into the result register as its event transaction.
// Throughput: one transaction per cycle when the sink does not stall; the only loop is
//   each lane's 32-bit timer subtract and compare.
// Reset (rst, synchronous): lane states and timers clear to zero, pipeline empties,
//   delay returns to 40 ms, rest levels to 0 and all pins enabled.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_pin_time_debouncer_macros.svh"
module multi_pin_time_debouncer #(
  parameter int NUM_PINS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mptd_pkg::PADDR_W-1:0]       paddr,
  input  logic [mptd_pkg::APB_DW-1:0]        pwdata,
  output logic [mptd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  mptd_in_if.sink                            samples,
  mptd_out_if.source                         events
);

  // Pin fields are eight bits wide; lanes past that never see input or report.
  localparam int LANES = (NUM_PINS < mptd_pkg::PIN_W) ? NUM_PINS : mptd_pkg::PIN_W;

  mptd_pkg::cfg_t        cfg;
  mptd_pkg::in_item_t    in_item;
  mptd_pkg::out_item_t   out_item;
  mptd_pkg::step_t       step;
  logic                  in_valid;
  logic                  out_valid;
  logic                  advance;
  logic [mptd_pkg::PIN_W-1:0] act_vec;
  logic [mptd_pkg::PIN_W-1:0] deact_vec;
  logic [mptd_pkg::PIN_W-1:0] level_vec;

  mptd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held sample into the lanes whenever the result register is free
  // or being drained this cycle; the input register refills in the same cycle.
  assign advance       = in_valid && (!out_valid || events.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  // Capture payload only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_item.restart    <= samples.restart;
      in_item.now_ms     <= samples.now_ms;
      in_item.pin_levels <= samples.pin_levels;
    end
  end

  assign step.valid          = advance;
  assign step.restart        = in_item.restart;
  assign step.now_ms         = in_item.now_ms;
  assign step.debounce_delay = cfg.debounce_delay;

  // One lane per pin; unused lanes report zero.
  for (genvar i = 0; i < mptd_pkg::PIN_W; i++) begin : g_lane
    if (i < LANES) begin : g_used
      mptd_pkg::lane_res_t res;

      mptd_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .step   (step),
        .sample (in_item.pin_levels[i]),
        .rest   (cfg.rest_levels[i]),
        .enable (cfg.pin_enable[i]),
        .res    (res)
      );

      assign act_vec[i]   = res.activated;
      assign deact_vec[i] = res.deactivated;
      assign level_vec[i] = res.level;
    end else begin : g_unused
      assign act_vec[i]   = 1'b0;
      assign deact_vec[i] = 1'b0;
      assign level_vec[i] = 1'b0;
    end
  end

  // Result register: load on advance, drop once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.activated_mask   <= act_vec;
      out_item.deactivated_mask <= deact_vec;
      out_item.debounced_levels <= level_vec;
    end
  end

  assign events.valid            = out_valid;
  assign events.activated_mask   = out_item.activated_mask;
  assign events.deactivated_mask = out_item.deactivated_mask;
  assign events.debounced_levels = out_item.debounced_levels;

  // A lane never raises both events at once.
  `MPTD_ASSERT_NOW(a_events_disjoint, clk, rst, out_valid,
    (out_item.activated_mask & out_item.deactivated_mask) == '0)
  // Events come only from enabled lanes.
  `MPTD_ASSERT_NOW(a_events_enabled, clk, rst, out_valid,
    ((out_item.activated_mask | out_item.deactivated_mask) & ~cfg.pin_enable) == '0)
  // Activation means the debounced level sits away from rest.
  `MPTD_ASSERT_NOW(a_act_off_rest, clk, rst, out_valid,
    (out_item.activated_mask & ~(out_item.debounced_levels ^ cfg.rest_levels)) == '0)
  // Deactivation means the debounced level is back at rest.
  `MPTD_ASSERT_NOW(a_deact_at_rest, clk, rst, out_valid,
    (out_item.deactivated_mask & (out_item.debounced_levels ^ cfg.rest_levels)) == '0)
  // Every step through the lanes lands in the result register.
  `MPTD_ASSERT_NEXT(a_step_lands, clk, rst, advance, out_valid)

endmodule
`default_nettype wire

// ----- tb/multi_pin_time_debouncer_tb.sv -----
// Testbench for the multi-pin time debouncer: directed and random samples against a predictor.
`timescale 1ns / 1ps
module multi_pin_time_debouncer_tb;

  localparam int CLK_HALF = 6;

  logic clk;
  logic rst;

  // APB configuration port
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mptd_pkg::PADDR_W-1:0] paddr;
  logic [mptd_pkg::APB_DW-1:0]  pwdata;
  logic [mptd_pkg::APB_DW-1:0]  prdata;
  logic                         pready;

  mptd_in_if  samples_if ();
  mptd_out_if events_if ();

  multi_pin_time_debouncer #(
    .NUM_PINS(mptd_pkg::PIN_W)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_if.sink),
    .events  (events_if.source)
  );

  always #CLK_HALF clk = ~clk;

  // Sample transactions waiting for the driver, and event transactions the
  // predictor says the block owes us, oldest first.
  mptd_pkg::in_item_t  pending_samples [$];
  mptd_pkg::out_item_t expected_events [$];

  int error_count;
  int send_max_gap;
  int recv_max_gap;

  // Predictor copy of the configuration registers.
  logic [mptd_pkg::DELAY_W-1:0] cfg_delay;
  logic [mptd_pkg::PIN_W-1:0]   cfg_rest;
  logic [mptd_pkg::PIN_W-1:0]   cfg_enable;

  // Predictor copy of the lane state.
  logic [mptd_pkg::PIN_W-1:0]  last_sample;
  logic [mptd_pkg::TIME_W-1:0] lane_timer [mptd_pkg::PIN_W];
  logic [mptd_pkg::PIN_W-1:0]  stable_pins;
  logic [mptd_pkg::PIN_W-1:0]  reported_pins;

  // Stimulus shaping: a slowly moving clock, the level the "user" holds on
  // each pin, and the lanes still bouncing after the last change.
  logic [mptd_pkg::TIME_W-1:0] sim_ms;
  logic [mptd_pkg::PIN_W-1:0]  target_pins;
  logic [mptd_pkg::PIN_W-1:0]  bounce_lanes;
  int                          bounce_left;

  // Driver and monitor scratch.
  mptd_pkg::in_item_t taken_sample;
  mptd_pkg::in_item_t next_sample;
  int                 send_wait;
  int                 send_hold;
  int                 recv_wait;
  int                 recv_hold;

  // Advance the lane state by one sample and return the event transaction it
  // causes. A restart reloads everything from the rest levels; otherwise each
  // lane restarts its timer on a raw change, accepts the raw level once the
  // wrapping elapsed time exceeds the delay, and enabled lanes report any
  // difference between accepted and last reported level.
  function automatic mptd_pkg::out_item_t debounce_step(mptd_pkg::in_item_t smp);
    mptd_pkg::out_item_t         res;
    logic [mptd_pkg::TIME_W-1:0] elapsed;
    res = '0;
    if (smp.restart) begin
      last_sample   = cfg_rest;
      stable_pins   = cfg_rest;
      reported_pins = cfg_rest;
      for (int i = 0; i < mptd_pkg::PIN_W; i++) lane_timer[i] = smp.now_ms;
    end else begin
      for (int i = 0; i < mptd_pkg::PIN_W; i++) begin
        if (smp.pin_levels[i] != last_sample[i]) lane_timer[i] = smp.now_ms;
        elapsed = smp.now_ms - lane_timer[i];
        if (elapsed > mptd_pkg::TIME_W'(cfg_delay)) begin
          lane_timer[i]  = smp.now_ms;
          stable_pins[i] = smp.pin_levels[i];
        end
      end
      last_sample = smp.pin_levels;
      // Disabled lanes keep their reported level, so a change stays pending.
      for (int i = 0; i < mptd_pkg::PIN_W; i++) begin
        if (cfg_enable[i]) begin
          if (reported_pins[i] != stable_pins[i]) begin
            if (stable_pins[i] == cfg_rest[i]) res.deactivated_mask[i] = 1'b1;
            else res.activated_mask[i] = 1'b1;
          end
          reported_pins[i] = stable_pins[i];
        end
      end
    end
    res.debounced_levels = stable_pins;
    return res;
  endfunction

  // Compare one event transaction against the oldest expectation.
  task automatic check_event(input mptd_pkg::out_item_t got);
    mptd_pkg::out_item_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event transaction, expected none, actual %02h/%02h/%02h",
               $time, got.activated_mask, got.deactivated_mask, got.debounced_levels);
      error_count++;
    end else begin
      want = expected_events.pop_front();
      if (got.activated_mask !== want.activated_mask) begin
        $display("%0t: activated_mask expected %02h actual %02h",
                 $time, want.activated_mask, got.activated_mask);
        error_count++;
      end
      if (got.deactivated_mask !== want.deactivated_mask) begin
        $display("%0t: deactivated_mask expected %02h actual %02h",
                 $time, want.deactivated_mask, got.deactivated_mask);
        error_count++;
      end
      if (got.debounced_levels !== want.debounced_levels) begin
        $display("%0t: debounced_levels expected %02h actual %02h",
                 $time, want.debounced_levels, got.debounced_levels);
        error_count++;
      end
    end
  endtask

  // Driver: present one sample per transaction, then hold valid low for a
  // drawn number of cycles before the next. Predict at the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      send_wait        <= 0;
    end else if (!samples_if.valid || samples_if.ready) begin
      if (samples_if.valid) begin
        taken_sample.restart    = samples_if.restart;
        taken_sample.now_ms     = samples_if.now_ms;
        taken_sample.pin_levels = samples_if.pin_levels;
        expected_events.push_back(debounce_step(taken_sample));
        send_hold = $urandom_range(0, send_max_gap);
      end else begin
        send_hold = send_wait;
      end
      if (send_hold == 0 && pending_samples.size() != 0) begin
        next_sample = pending_samples.pop_front();
        samples_if.restart    <= next_sample.restart;
        samples_if.now_ms     <= next_sample.now_ms;
        samples_if.pin_levels <= next_sample.pin_levels;
        samples_if.valid      <= 1'b1;
        send_wait             <= 0;
      end else begin
        samples_if.valid <= 1'b0;
        send_wait        <= (send_hold == 0) ? 0 : send_hold - 1;
      end
    end
  end

  // Monitor: check each event transaction, then stall ready for a drawn
  // number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      events_if.ready <= 1'b0;
      recv_wait       <= 0;
    end else begin
      if (events_if.valid && events_if.ready) begin
        check_event('{activated_mask:   events_if.activated_mask,
                      deactivated_mask: events_if.deactivated_mask,
                      debounced_levels: events_if.debounced_levels});
        recv_hold = $urandom_range(0, recv_max_gap);
      end else begin
        recv_hold = recv_wait;
      end
      if (recv_hold == 0) begin
        events_if.ready <= 1'b1;
        recv_wait       <= 0;
      end else begin
        events_if.ready <= 1'b0;
        recv_wait       <= recv_hold - 1;
      end
    end
  end

  // One APB transfer: setup cycle, access cycle, complete on pready.
  task automatic apb_access(input logic wr, input logic [mptd_pkg::REG_IDX_W-1:0] idx,
                            input logic [mptd_pkg::APB_DW-1:0] wdata,
                            output logic [mptd_pkg::APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= mptd_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [mptd_pkg::REG_IDX_W-1:0] idx,
                           input logic [mptd_pkg::APB_DW-1:0] want);
    logic [mptd_pkg::APB_DW-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want) begin
      $display("%0t: register %0d readback expected %08h actual %08h", $time, idx, want, got);
      error_count++;
    end
  endtask

  // Write a register, mirror it in the predictor, then read it back.
  task automatic write_reg(input logic [mptd_pkg::REG_IDX_W-1:0] idx,
                           input logic [mptd_pkg::APB_DW-1:0] value);
    logic [mptd_pkg::APB_DW-1:0] unused;
    logic [mptd_pkg::APB_DW-1:0] stored;
    apb_access(1'b1, idx, value, unused);
    stored = '0;
    unique case (idx)
      mptd_pkg::REG_DELAY: begin
        cfg_delay = value[mptd_pkg::DELAY_W-1:0];
        stored    = mptd_pkg::APB_DW'(cfg_delay);
      end
      mptd_pkg::REG_REST: begin
        cfg_rest = value[mptd_pkg::PIN_W-1:0];
        stored   = mptd_pkg::APB_DW'(cfg_rest);
      end
      mptd_pkg::REG_ENABLE: begin
        cfg_enable = value[mptd_pkg::PIN_W-1:0];
        stored     = mptd_pkg::APB_DW'(cfg_enable);
      end
      default: ;
    endcase
    check_reg(idx, stored);
  endtask

  task automatic queue_sample(input logic rs, input logic [mptd_pkg::TIME_W-1:0] t,
                              input logic [mptd_pkg::PIN_W-1:0] pins);
    mptd_pkg::in_item_t smp;
    smp.restart    = rs;
    smp.now_ms     = t;
    smp.pin_levels = pins;
    pending_samples.push_back(smp);
  endtask

  function automatic bit stream_idle();
    return pending_samples.size() == 0 && !samples_if.valid && expected_events.size() == 0;
  endfunction

  // Hold off until every queued sample is accepted and every event is back.
  task automatic drain_events();
    do @(negedge clk); while (!stream_idle());
  endtask

  // Random samples: mostly a held level per pin with short bounce bursts and
  // a clock that creeps forward on the scale of the delay; some restarts and
  // some samples with an arbitrary timestamp. Pause for a full drain at
  // pause_at if it is in range.
  task automatic queue_random(input int count, input int pause_at);
    int                         roll;
    int unsigned                step_max;
    logic [mptd_pkg::PIN_W-1:0] flip;
    logic [mptd_pkg::PIN_W-1:0] pins;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain_events();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        queue_sample(1'b1, sim_ms, mptd_pkg::PIN_W'($urandom));
      end else if (roll < 8) begin
        queue_sample(1'b0, mptd_pkg::TIME_W'($urandom), mptd_pkg::PIN_W'($urandom));
      end else begin
        step_max = ($urandom_range(0, 9) == 0) ? 2 * int'(cfg_delay) + 2
                                               : int'(cfg_delay) / 2 + 2;
        sim_ms += $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < 15) begin
          flip = mptd_pkg::PIN_W'($urandom);
          if (flip == '0) flip = 8'h01;
          target_pins  ^= flip;
          bounce_lanes  = flip;
          bounce_left   = $urandom_range(0, 4);
        end
        pins = target_pins;
        if (bounce_left != 0) begin
          pins ^= mptd_pkg::PIN_W'($urandom) & bounce_lanes;
          bounce_left--;
        end
        queue_sample(1'b0, sim_ms, pins);
      end
    end
  endtask

  // Phase table for the random part: delay, rest levels, enable mask.
  logic [mptd_pkg::DELAY_W-1:0] delay_tab [8] = '{16'd0, 16'd5, 16'd40, 16'd1,
                                                  16'd65535, 16'd65535, 16'd300, 16'd12};
  logic [mptd_pkg::PIN_W-1:0]   rest_tab  [8] = '{8'h00, 8'hA5, 8'h00, 8'hFF,
                                                  8'hFF, 8'h3C, 8'h00, 8'h00};
  logic [mptd_pkg::PIN_W-1:0]   en_tab    [8] = '{8'hFF, 8'hFF, 8'h00, 8'h0F,
                                                  8'h00, 8'hFF, 8'h00, 8'hFF};

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    samples_if.valid      = 1'b0;
    samples_if.restart    = 1'b0;
    samples_if.now_ms     = '0;
    samples_if.pin_levels = '0;
    events_if.ready       = 1'b0;
    error_count  = 0;
    send_max_gap = 5;
    recv_max_gap = 5;
    cfg_delay    = mptd_pkg::DELAY_RESET;
    cfg_rest     = mptd_pkg::REST_RESET;
    cfg_enable   = mptd_pkg::ENABLE_RESET;
    last_sample   = '0;
    stable_pins   = '0;
    reported_pins = '0;
    for (int i = 0; i < mptd_pkg::PIN_W; i++) lane_timer[i] = '0;
    sim_ms       = '0;
    target_pins  = '0;
    bounce_lanes = '0;
    bounce_left  = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers.
    check_reg(mptd_pkg::REG_DELAY, mptd_pkg::APB_DW'(mptd_pkg::DELAY_RESET));
    check_reg(mptd_pkg::REG_REST, mptd_pkg::APB_DW'(mptd_pkg::REST_RESET));
    check_reg(mptd_pkg::REG_ENABLE, mptd_pkg::APB_DW'(mptd_pkg::ENABLE_RESET));
    @(negedge clk);

    // Directed, default configuration: a press exactly at and just past the
    // delay, a release, a bounce, then a restart just before the clock wraps
    // and a press timed across the wrap.
    queue_sample(1'b0, 32'd0,   8'hFF);
    queue_sample(1'b0, 32'd40,  8'hFF);
    queue_sample(1'b0, 32'd41,  8'hFF);
    queue_sample(1'b0, 32'd41,  8'h00);
    queue_sample(1'b0, 32'd82,  8'h00);
    queue_sample(1'b0, 32'd82,  8'h5A);
    queue_sample(1'b0, 32'd82,  8'hA5);
    queue_sample(1'b0, 32'd200, 8'hA5);
    queue_sample(1'b1, 32'hFFFF_FFF0, 8'hAA);
    queue_sample(1'b0, 32'hFFFF_FFFF, 8'h00);
    queue_sample(1'b0, 32'h0000_0019, 8'h00);
    queue_sample(1'b0, 32'h0000_001A, 8'hF0);
    queue_sample(1'b0, 32'h0000_0043, 8'hF0);
    drain_events();

    // Zero delay, mixed rest levels, half the lanes disabled.
    write_reg(mptd_pkg::REG_DELAY, 32'd0);
    write_reg(mptd_pkg::REG_REST, 32'h0F);
    write_reg(mptd_pkg::REG_ENABLE, 32'h33);
    @(negedge clk);
    queue_sample(1'b1, 32'd100, 8'h00);
    queue_sample(1'b0, 32'd100, 8'hF0);
    queue_sample(1'b0, 32'd101, 8'hF0);
    drain_events();

    // Re-enable: the held-back changes fire on the next sample.
    write_reg(mptd_pkg::REG_ENABLE, 32'hFF);
    @(negedge clk);
    queue_sample(1'b0, 32'd101, 8'hF0);
    queue_sample(1'b0, 32'd102, 8'h0F);
    queue_sample(1'b0, 32'd103, 8'h0F);
    drain_events();

    // Random phases. Alternate sender gaps and receiver stalls so every
    // combination of idling and back-to-back traffic shows up.
    for (int p = 0; p < 8; p++) begin
      write_reg(mptd_pkg::REG_DELAY, mptd_pkg::APB_DW'(delay_tab[p]));
      write_reg(mptd_pkg::REG_REST,
                mptd_pkg::APB_DW'((p == 2 || p == 6) ? mptd_pkg::PIN_W'($urandom)
                                                     : rest_tab[p]));
      write_reg(mptd_pkg::REG_ENABLE,
                mptd_pkg::APB_DW'((p == 2 || p == 6) ? mptd_pkg::PIN_W'($urandom)
                                                     : en_tab[p]));
      @(negedge clk);
      send_max_gap = (p % 2 == 0) ? 5 : 0;
      recv_max_gap = ((p / 2) % 2 == 0) ? 5 : 0;
      if (p == 1) sim_ms = 32'hFFFF_FF00;
      if (p == 4) sim_ms = 32'hFFF0_0000;
      target_pins = cfg_rest;
      queue_sample(1'b1, sim_ms, mptd_pkg::PIN_W'($urandom));
      queue_random(75, (p == 2 || p == 5) ? 37 : -1);
      drain_events();
    end

    // Let any stray transaction surface, then judge.
    for (int n = 0; n < 2000 && !stream_idle(); n++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_events.size() != 0) begin
      $display("%0t: %0d event transactions never arrived", $time, expected_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2400000;
    $display("Verification failed");
    $finish;
  end

endmodule
